// ----- rtl/lmss_pkg.sv -----
// ----------------------------------------------------------------------------
// lmss_pkg
// Shared types and constants of the LCD scanline mode sequencer.
// ----------------------------------------------------------------------------
package lmss_pkg;

   // mode codes
   localparam logic [1:0] MODE_HBLANK   = 2'd0;
   localparam logic [1:0] MODE_VBLANK   = 2'd1;
   localparam logic [1:0] MODE_OAM      = 2'd2;
   localparam logic [1:0] MODE_TRANSFER = 2'd3;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPARE_LINE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COINCIDENCE_EN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VBLANK_STAT_EN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OAM_STAT_EN    = 3'd3;
   localparam int CSR_DATA_W = 8;

   // widths and limits
   localparam int LEN_W  = 9;   // mode lengths up to 511
   localparam int CYC_W  = 11;  // leftover (<=1023) plus one item (<=255)
   localparam int STEP_W = 3;
   localparam int MAX_STEPS = 8;
   localparam logic [7:0] LAST_LINE = 8'd153;
   localparam logic [CYC_W-1:0] LEFTOVER_MAX = 11'd1023;

   // configuration registers as seen by the back end
   typedef struct packed {
      logic [7:0] compare_line;
      logic       coincidence_irq_enable;
      logic       vblank_stat_irq_enable;
      logic       oam_stat_irq_enable;
   } cfg_type;

   // head of the item queue toward the back end
   typedef struct packed {
      logic       valid;
      logic [7:0] elapsed_cycles;
   } queue_head_type;

endpackage

// ----- rtl/lmss_front.sv -----
// ----------------------------------------------------------------------------
// lmss_front
// Accepts input transactions into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lmss_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_elapsed_cycles,
   output lmss_pkg::queue_head_type head,
   input  logic                    pop
);

   logic [7:0] entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       do_pop;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (count_ff != 2'd0);

   assign head.valid          = (count_ff != 2'd0);
   assign head.elapsed_cycles = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push   ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_elapsed_cycles;
      end
   end

endmodule

// ----- rtl/lmss_back.sv -----
// ----------------------------------------------------------------------------
// lmss_back
// Mode stepper: consumes queued cycle counts, one mode step per cycle while
// the result register is free, and drives the registered result channel.
// ----------------------------------------------------------------------------
module lmss_back #(
   parameter int HBLANK_CYCLES      = 204,
   parameter int OAM_CYCLES         = 80,
   parameter int TRANSFER_CYCLES    = 172,
   parameter int VBLANK_LINE_CYCLES = 456,
   parameter int VBLANK_LINES       = 10,
   parameter int VISIBLE_LINES      = 144
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lmss_pkg::cfg_type        cfg,
   input  lmss_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_new_mode,
   output logic [7:0]               rsp_current_line,
   output logic                     rsp_line_rendered,
   output logic                     rsp_frame_done,
   output logic                     rsp_vblank_irq,
   output logic                     rsp_stat_irq,
   output logic                     rsp_last_step
);

   localparam int CW = lmss_pkg::CYC_W;
   localparam int LW = lmss_pkg::LEN_W;
   localparam logic [LW-1:0] LEN_HB  = LW'(HBLANK_CYCLES);
   localparam logic [LW-1:0] LEN_OAM = LW'(OAM_CYCLES);
   localparam logic [LW-1:0] LEN_TR  = LW'(TRANSFER_CYCLES);
   localparam logic [LW-1:0] LEN_VB  = LW'(VBLANK_LINE_CYCLES);
   localparam logic [3:0]    VB_LINES  = 4'(VBLANK_LINES);
   localparam logic [7:0]    VIS_LINES = 8'(VISIBLE_LINES);
   localparam logic [lmss_pkg::STEP_W-1:0] LAST_STEP_IDX =
      lmss_pkg::STEP_W'(lmss_pkg::MAX_STEPS - 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_STEP = 1'b1;

   function automatic logic [LW-1:0] len_of(input logic [1:0] m);
      logic [LW-1:0] l;
      case (m)
         lmss_pkg::MODE_HBLANK:   l = LEN_HB;
         lmss_pkg::MODE_VBLANK:   l = LEN_VB;
         lmss_pkg::MODE_OAM:      l = LEN_OAM;
         lmss_pkg::MODE_TRANSFER: l = LEN_TR;
         default:                 l = LEN_TR;
      endcase
      return l;
   endfunction

   logic                          state_ff, state_in;
   logic [CW-1:0]                 cycles_ff, cycles_in;
   logic [1:0]                    mode_ff, mode_in;
   logic [7:0]                    line_ff, line_in;
   logic [3:0]                    vcnt_ff, vcnt_in;
   logic [lmss_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    o_mode_ff;
   logic [7:0]                    o_line_ff;
   logic                          o_rend_ff, o_frame_ff, o_vbl_ff, o_stat_ff, o_last_ff;

   logic [CW-1:0] len_ext, next_c, next_c_sat;
   logic          exceed, out_free, emit, last;
   logic [1:0]    s_mode;
   logic [7:0]    s_line, inc_line;
   logic [3:0]    s_vcnt;
   logic          s_rend, s_frame, s_vbl, s_stat;

   // one mode step from the current state
   always_comb begin
      s_mode   = mode_ff;
      s_line   = line_ff;
      s_vcnt   = vcnt_ff;
      s_rend   = 1'b0;
      s_frame  = 1'b0;
      s_vbl    = 1'b0;
      s_stat   = 1'b0;
      inc_line = line_ff + 8'd1;
      case (mode_ff)
         lmss_pkg::MODE_HBLANK: begin
            if (line_ff <= VIS_LINES) begin
               // coincidence on the line before it advances
               s_stat = cfg.coincidence_irq_enable && (line_ff == cfg.compare_line);
               s_rend = 1'b1;
               s_line = inc_line;
            end
            if (s_line >= VIS_LINES) begin
               s_mode  = lmss_pkg::MODE_VBLANK;
               s_frame = 1'b1;
               s_vbl   = 1'b1;
               s_stat  = s_stat || cfg.vblank_stat_irq_enable;
            end else begin
               s_mode = lmss_pkg::MODE_OAM;
            end
         end
         lmss_pkg::MODE_VBLANK: begin
            if (vcnt_ff >= VB_LINES) begin
               s_mode = lmss_pkg::MODE_OAM;
               s_vcnt = 4'd0;
               s_line = 8'd0;
            end else begin
               // coincidence on the advanced line, before the clamp
               s_line = inc_line;
               s_stat = cfg.coincidence_irq_enable && (inc_line == cfg.compare_line);
               s_vcnt = vcnt_ff + 4'd1;
            end
            if (s_line > lmss_pkg::LAST_LINE) begin
               s_line = lmss_pkg::LAST_LINE;
            end
         end
         lmss_pkg::MODE_OAM: begin
            s_stat = cfg.oam_stat_irq_enable;
            s_mode = lmss_pkg::MODE_TRANSFER;
         end
         default: begin
            s_mode = lmss_pkg::MODE_HBLANK;
         end
      endcase
   end

   // cycle budget and look-ahead for the final step of an item
   always_comb begin
      len_ext    = CW'(len_of(mode_ff));
      exceed     = cycles_ff > len_ext;
      next_c     = cycles_ff - len_ext;
      next_c_sat = (next_c > lmss_pkg::LEFTOVER_MAX) ? lmss_pkg::LEFTOVER_MAX : next_c;
      last       = (step_ff == LAST_STEP_IDX) || (next_c <= CW'(len_of(s_mode)));
      out_free   = !rsp_valid_ff || rsp_ready;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cycles_in = cycles_ff;
      mode_in   = mode_ff;
      line_in   = line_ff;
      vcnt_in   = vcnt_ff;
      step_in   = step_ff;
      pop       = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop       = 1'b1;
               cycles_in = cycles_ff + CW'(head.elapsed_cycles);
               step_in   = '0;
               state_in  = ST_STEP;
            end
         end
         ST_STEP: begin
            if (!exceed) begin
               // no step at all: the sum stays as leftover
               state_in = ST_IDLE;
            end else if (out_free) begin
               emit    = 1'b1;
               mode_in = s_mode;
               line_in = s_line;
               vcnt_in = s_vcnt;
               step_in = step_ff + {{(lmss_pkg::STEP_W-1){1'b0}}, 1'b1};
               if (last) begin
                  cycles_in = next_c_sat;
                  state_in  = ST_IDLE;
               end else begin
                  cycles_in = next_c;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cycles_ff    <= '0;
         mode_ff      <= lmss_pkg::MODE_HBLANK;
         line_ff      <= 8'd0;
         vcnt_ff      <= 4'd0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cycles_ff    <= cycles_in;
         mode_ff      <= mode_in;
         line_ff      <= line_in;
         vcnt_ff      <= vcnt_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (emit) begin
         o_mode_ff  <= s_mode;
         o_line_ff  <= s_line;
         o_rend_ff  <= s_rend;
         o_frame_ff <= s_frame;
         o_vbl_ff   <= s_vbl;
         o_stat_ff  <= s_stat;
         o_last_ff  <= last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_mode      = o_mode_ff;
   assign rsp_current_line  = o_line_ff;
   assign rsp_line_rendered = o_rend_ff;
   assign rsp_frame_done    = o_frame_ff;
   assign rsp_vblank_irq    = o_vbl_ff;
   assign rsp_stat_irq      = o_stat_ff;
   assign rsp_last_step     = o_last_ff;

endmodule

// ----- rtl/lcd_mode_scanline_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// lcd_mode_scanline_sequencer_core
// LCD scanline mode sequencer: cycle counts in, one result per mode step out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_elapsed_cycles
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_new_mode .. rsp_last_step
//  csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
//  An item is loaded into the stepper from its idle state; its single-step loop
//  then makes one mode step per cycle (0 to 8 steps) while the output is free;
//  an item that causes no step still gets one check. A two-entry queue takes
//  new items while the stepper works; the result register stalls the
//  stepper only while a result waits. Reset is synchronous and needs no
//  clearing pass.
// ----------------------------------------------------------------------------
module lcd_mode_scanline_sequencer_core #(
   parameter int HBLANK_CYCLES      = 204,
   parameter int OAM_CYCLES         = 80,
   parameter int TRANSFER_CYCLES    = 172,
   parameter int VBLANK_LINE_CYCLES = 456,
   parameter int VBLANK_LINES       = 10,
   parameter int VISIBLE_LINES      = 144
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_elapsed_cycles,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_new_mode,
   output logic [7:0]                       rsp_current_line,
   output logic                             rsp_line_rendered,
   output logic                             rsp_frame_done,
   output logic                             rsp_vblank_irq,
   output logic                             rsp_stat_irq,
   output logic                             rsp_last_step,
   input  logic                             csr_wr_en,
   input  logic [lmss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lmss_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   lmss_pkg::cfg_type        cfg_ff, cfg_in;
   lmss_pkg::queue_head_type head;
   logic                     pop;

   // configuration registers; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            lmss_pkg::CSR_COMPARE_LINE:   cfg_in.compare_line           = csr_wdata;
            lmss_pkg::CSR_COINCIDENCE_EN: cfg_in.coincidence_irq_enable = csr_wdata[0];
            lmss_pkg::CSR_VBLANK_STAT_EN: cfg_in.vblank_stat_irq_enable = csr_wdata[0];
            lmss_pkg::CSR_OAM_STAT_EN:    cfg_in.oam_stat_irq_enable    = csr_wdata[0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lmss_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_elapsed_cycles (req_elapsed_cycles),
      .head               (head),
      .pop                (pop)
   );

   lmss_back #(
      .HBLANK_CYCLES      (HBLANK_CYCLES),
      .OAM_CYCLES         (OAM_CYCLES),
      .TRANSFER_CYCLES    (TRANSFER_CYCLES),
      .VBLANK_LINE_CYCLES (VBLANK_LINE_CYCLES),
      .VBLANK_LINES       (VBLANK_LINES),
      .VISIBLE_LINES      (VISIBLE_LINES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_new_mode      (rsp_new_mode),
      .rsp_current_line  (rsp_current_line),
      .rsp_line_rendered (rsp_line_rendered),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_vblank_irq    (rsp_vblank_irq),
      .rsp_stat_irq      (rsp_stat_irq),
      .rsp_last_step     (rsp_last_step)
   );

endmodule

// ----- rtl/lmss_checker.sv -----
// ----------------------------------------------------------------------------
// lmss_checker
// Port-level checks of the scanline mode sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lmss_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_new_mode,
   input logic [7:0] rsp_current_line,
   input logic       rsp_line_rendered,
   input logic       rsp_frame_done,
   input logic       rsp_vblank_irq
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_mode)
                                 && $stable(rsp_current_line))
      else $error("result changed while stalled");

   // the line counter never passes the last line
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_current_line <= lmss_pkg::LAST_LINE)
      else $error("line counter beyond last line");

   // entering vblank always raises the vblank request and lands in vblank
   a_frame_vblank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_vblank_irq
                                      && rsp_new_mode == lmss_pkg::MODE_VBLANK)
      else $error("frame done without vblank entry");

   // a rendered line comes only from an hblank step
   a_render_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_rendered |-> rsp_new_mode == lmss_pkg::MODE_OAM
                                         || rsp_new_mode == lmss_pkg::MODE_VBLANK)
      else $error("line rendered outside an hblank step");

endmodule

bind lcd_mode_scanline_sequencer_core lmss_checker u_lmss_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_new_mode      (rsp_new_mode),
   .rsp_current_line  (rsp_current_line),
   .rsp_line_rendered (rsp_line_rendered),
   .rsp_frame_done    (rsp_frame_done),
   .rsp_vblank_irq    (rsp_vblank_irq)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LCD scanline mode sequencer. Cycle counts go in
// over the req channel, and a local model of the mode/line state predicts
// every mode-step result. Results are compared field by field in arrival
// order. A short stimulus table comes first, then random traffic in phases,
// with the CSRs reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int HBLANK_LEN    = 204;
   localparam int OAM_LEN       = 80;
   localparam int TRANSFER_LEN  = 172;
   localparam int VBLANK_LEN    = 456;
   localparam int VBLANK_STEPS  = 10;
   localparam int VISIBLE_LINES = 144;

   // queue of two items plus the stepper, each up to eight steps, plus slack
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 59;
   localparam logic [lmss_pkg::CSR_IDX_W-1:0] CSR_SPARE = lmss_pkg::CSR_OAM_STAT_EN + 3'd1;

   typedef struct packed {
      logic [1:0] new_mode;
      logic [7:0] line;
      logic       rendered;
      logic       frame_done;
      logic       vblank_irq;
      logic       stat_irq;
      logic       last_step;
   } scan_step_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                   kind;
      logic [lmss_pkg::CSR_IDX_W-1:0] idx;
      logic [7:0]                     value;
      bit                             typed;
      int                             exp_n;
      scan_step_type                  exp;
   } plan_row_type;

   logic                            clock;
   logic                            reset              = 1'b1;
   logic                            req_valid          = 1'b0;
   logic                            req_ready;
   logic [7:0]                      req_elapsed_cycles = 8'd0;
   logic                            rsp_valid;
   logic                            rsp_ready          = 1'b0;
   logic [1:0]                      rsp_new_mode;
   logic [7:0]                      rsp_current_line;
   logic                            rsp_line_rendered;
   logic                            rsp_frame_done;
   logic                            rsp_vblank_irq;
   logic                            rsp_stat_irq;
   logic                            rsp_last_step;
   logic                            csr_wr_en          = 1'b0;
   logic [lmss_pkg::CSR_IDX_W-1:0]  csr_index          = '0;
   logic [lmss_pkg::CSR_DATA_W-1:0] csr_wdata          = '0;

   // model state and register copy
   logic [1:0] cur_mode;
   logic [7:0] cur_line;
   logic [3:0] vbl_steps;
   logic [9:0] left_cyc;
   logic [7:0] cmp_line;
   logic       coin_en;
   logic       vbl_stat_en;
   logic       oam_stat_en;

   scan_step_type new_steps[$];
   scan_step_type due_steps[$];
   plan_row_type  plan[$];
   int            mismatch_count = 0;
   bit            calm = 1'b0;

   lcd_mode_scanline_sequencer_core #(
      .HBLANK_CYCLES      (HBLANK_LEN),
      .OAM_CYCLES         (OAM_LEN),
      .TRANSFER_CYCLES    (TRANSFER_LEN),
      .VBLANK_LINE_CYCLES (VBLANK_LEN),
      .VBLANK_LINES       (VBLANK_STEPS),
      .VISIBLE_LINES      (VISIBLE_LINES)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_elapsed_cycles (req_elapsed_cycles),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_new_mode       (rsp_new_mode),
      .rsp_current_line   (rsp_current_line),
      .rsp_line_rendered  (rsp_line_rendered),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_vblank_irq     (rsp_vblank_irq),
      .rsp_stat_irq       (rsp_stat_irq),
      .rsp_last_step      (rsp_last_step),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 50 MHz clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   function automatic int unsigned mode_span(input logic [1:0] mode);
      case (mode)
         lmss_pkg::MODE_HBLANK: return HBLANK_LEN;
         lmss_pkg::MODE_VBLANK: return VBLANK_LEN;
         lmss_pkg::MODE_OAM:    return OAM_LEN;
         default:               return TRANSFER_LEN;
      endcase
   endfunction

   // Consume the cycle budget one mode at a time; one result per step.
   task automatic advance_scanline(input logic [7:0] elapsed);
      logic [10:0]   budget;
      int unsigned   span;
      scan_step_type s;
      budget = 11'(left_cyc) + 11'(elapsed);
      new_steps.delete();
      while (new_steps.size() < lmss_pkg::MAX_STEPS) begin
         span = mode_span(cur_mode);
         if (budget <= span) break;
         s = '0;
         case (cur_mode)
            lmss_pkg::MODE_HBLANK: begin
               // coincidence is seen on the line before it advances
               if (cur_line <= VISIBLE_LINES) begin
                  if (coin_en && cur_line == cmp_line) s.stat_irq = 1'b1;
                  s.rendered = 1'b1;
                  cur_line   = cur_line + 8'd1;
               end
               if (cur_line >= VISIBLE_LINES) begin
                  cur_mode     = lmss_pkg::MODE_VBLANK;
                  s.frame_done = 1'b1;
                  s.vblank_irq = 1'b1;
                  if (vbl_stat_en) s.stat_irq = 1'b1;
               end else begin
                  cur_mode = lmss_pkg::MODE_OAM;
               end
            end
            lmss_pkg::MODE_VBLANK: begin
               // coincidence on the advanced line, ahead of the clamp
               if (vbl_steps >= VBLANK_STEPS) begin
                  cur_mode  = lmss_pkg::MODE_OAM;
                  vbl_steps = 4'd0;
                  cur_line  = 8'd0;
               end else begin
                  cur_line = cur_line + 8'd1;
                  if (coin_en && cur_line == cmp_line) s.stat_irq = 1'b1;
                  vbl_steps = vbl_steps + 4'd1;
               end
               if (cur_line > lmss_pkg::LAST_LINE) cur_line = lmss_pkg::LAST_LINE;
            end
            lmss_pkg::MODE_OAM: begin
               if (oam_stat_en) s.stat_irq = 1'b1;
               cur_mode = lmss_pkg::MODE_TRANSFER;
            end
            default: begin
               cur_mode = lmss_pkg::MODE_HBLANK;
            end
         endcase
         budget     = budget - 11'(span);
         s.new_mode = cur_mode;
         s.line     = cur_line;
         new_steps.push_back(s);
      end
      if (new_steps.size() != 0) begin
         s = new_steps.pop_back();
         s.last_step = 1'b1;
         new_steps.push_back(s);
      end
      left_cyc = (budget > lmss_pkg::LEFTOVER_MAX) ? lmss_pkg::LEFTOVER_MAX[9:0] : budget[9:0];
   endtask

   function automatic scan_step_type known_step(input logic [1:0] mode,
                                                input logic [7:0] line,
                                                input logic rendered);
      scan_step_type s;
      s           = '0;
      s.new_mode  = mode;
      s.line      = line;
      s.rendered  = rendered;
      s.last_step = 1'b1;
      return s;
   endfunction

   task automatic plan_item(input logic [7:0] value);
      plan_row_type r;
      r = '{ROW_ITEM, '0, value, 1'b0, 0, '0};
      plan.push_back(r);
   endtask

   task automatic plan_known(input logic [7:0] value, input int n, input scan_step_type exp);
      plan_row_type r;
      r = '{ROW_ITEM, '0, value, 1'b1, n, exp};
      plan.push_back(r);
   endtask

   task automatic plan_csr(input logic [lmss_pkg::CSR_IDX_W-1:0] idx, input logic [7:0] value);
      plan_row_type r;
      r = '{ROW_CSR, idx, value, 1'b0, 0, '0};
      plan.push_back(r);
   endtask

   // One CSR write; the caller drops the write enable after the last one.
   task automatic write_reg(input logic [lmss_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         lmss_pkg::CSR_COMPARE_LINE:   cmp_line    = value;
         lmss_pkg::CSR_COINCIDENCE_EN: coin_en     = value[0];
         lmss_pkg::CSR_VBLANK_STAT_EN: vbl_stat_en = value[0];
         lmss_pkg::CSR_OAM_STAT_EN:    oam_stat_en = value[0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [7:0] cmp, input logic coin, input logic vbl,
                               input logic oam);
      write_reg(lmss_pkg::CSR_COMPARE_LINE, cmp);
      write_reg(lmss_pkg::CSR_COINCIDENCE_EN, {7'($urandom), coin});
      write_reg(lmss_pkg::CSR_VBLANK_STAT_EN, {7'($urandom), vbl});
      write_reg(lmss_pkg::CSR_OAM_STAT_EN, {7'($urandom), oam});
      // unmapped index, must be ignored
      write_reg(CSR_SPARE + lmss_pkg::CSR_IDX_W'($urandom_range(3)), 8'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   // Hold off until every result is in and the stepper has gone quiet.
   task automatic settle_pipe();
      req_valid <= 1'b0;
      while (due_steps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Present one transaction, then predict its results once it is taken.
   task automatic send_item(input logic [7:0] value, input bit typed, input int exp_n,
                            input scan_step_type exp);
      while (!calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_elapsed_cycles <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_scanline(value);
      if (typed) begin
         if (new_steps.size() != exp_n || (exp_n == 1 && new_steps[0] != exp))
            flag_mismatch("table row vs model step count", new_steps.size(), exp_n);
         if (exp_n == 1) due_steps.push_back(exp);
      end else begin
         foreach (new_steps[i]) due_steps.push_back(new_steps[i]);
      end
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 28);
   end

   // result checker
   always @(posedge clock) begin : rsp_check
      scan_step_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_new_mode, rsp_current_line, rsp_line_rendered, rsp_frame_done,
                rsp_vblank_irq, rsp_stat_irq, rsp_last_step};
         if (due_steps.size() == 0) begin
            flag_mismatch("transaction with nothing expected", got.line, 0);
         end else begin
            want = due_steps.pop_front();
            if (got.new_mode != want.new_mode)
               flag_mismatch("new_mode", got.new_mode, want.new_mode);
            if (got.line != want.line)
               flag_mismatch("current_line", got.line, want.line);
            if (got.rendered != want.rendered)
               flag_mismatch("line_rendered", got.rendered, want.rendered);
            if (got.frame_done != want.frame_done)
               flag_mismatch("frame_done", got.frame_done, want.frame_done);
            if (got.vblank_irq != want.vblank_irq)
               flag_mismatch("vblank_irq", got.vblank_irq, want.vblank_irq);
            if (got.stat_irq != want.stat_irq)
               flag_mismatch("stat_irq", got.stat_irq, want.stat_irq);
            if (got.last_step != want.last_step)
               flag_mismatch("last_step", got.last_step, want.last_step);
         end
      end
   end

   // main sequence
   initial begin
      int         phase, k;
      logic [7:0] cmp;
      logic [7:0] cyc;

      cur_mode    = lmss_pkg::MODE_HBLANK;
      cur_line    = 8'd0;
      vbl_steps   = 4'd0;
      left_cyc    = 10'd0;
      cmp_line    = 8'd0;
      coin_en     = 1'b0;
      vbl_stat_en = 1'b0;
      oam_stat_en = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      program_regs(8'd0, 1'b0, 1'b0, 1'b0);

      // directed: budget boundaries after reset, then each mode and irq source
      plan_known(8'd0, 0, '0);
      plan_known(8'd204, 0, '0);   // equal to hblank length, no step
      plan_known(8'd1, 1, known_step(lmss_pkg::MODE_OAM, 8'd1, 1'b1));
      plan_known(8'd80, 1, known_step(lmss_pkg::MODE_TRANSFER, 8'd1, 1'b0));
      plan_known(8'd255, 1, known_step(lmss_pkg::MODE_HBLANK, 8'd1, 1'b0));
      plan_csr(lmss_pkg::CSR_COMPARE_LINE, 8'd1);
      plan_csr(lmss_pkg::CSR_COINCIDENCE_EN, 8'd1);
      plan_csr(lmss_pkg::CSR_OAM_STAT_EN, 8'd1);
      plan_item(8'd255);
      plan_item(8'd255);
      plan_item(8'd255);
      plan_item(8'd0);
      plan_item(8'd128);
      plan_csr(lmss_pkg::CSR_VBLANK_STAT_EN, 8'd1);
      plan_csr(lmss_pkg::CSR_COMPARE_LINE, 8'd255);
      plan_csr(CSR_SPARE, 8'hFF);
      plan_item(8'd255);
      plan_item(8'd1);
      plan_item(8'd254);
      plan_item(8'd170);
      plan_item(8'd85);
      plan_item(8'd255);
      plan_item(8'd255);
      plan_csr(lmss_pkg::CSR_COMPARE_LINE, 8'd0);
      plan_csr(lmss_pkg::CSR_COINCIDENCE_EN, 8'd0);
      plan_item(8'd255);
      plan_item(8'd200);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle_pipe();
            write_reg(plan[i].idx, plan[i].value);
            csr_wr_en <= 1'b0;
         end else begin
            send_item(plan[i].value, plan[i].typed, plan[i].exp_n, plan[i].exp);
         end
      end

      // random traffic: mostly large counts so that the frame reaches vblank
      for (phase = 0; phase < PHASES; phase++) begin
         settle_pipe();
         case ($urandom_range(4))
            0:       cmp = 8'd0;
            1:       cmp = 8'd255;
            2:       cmp = (cur_line > 8'd100) ? 8'd154 : cur_line + 8'd5;
            3:       cmp = cur_line + 8'($urandom_range(1, 40));
            default: cmp = 8'($urandom);
         endcase
         if (phase == 0)
            program_regs(8'd0, 1'b1, 1'b1, 1'b1);
         else if (phase == 1)
            program_regs(8'd255, 1'b0, 1'b0, 1'b0);
         else
            program_regs(cmp, 1'($urandom), 1'($urandom), 1'($urandom));
         calm = (phase == 3);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            cyc = ($urandom_range(9) != 0) ? 8'($urandom_range(255, 200)) : 8'($urandom);
            send_item(cyc, 1'b0, 0, '0);
         end
      end

      settle_pipe();
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lmss_pkg.sv
rtl/lmss_front.sv
rtl/lmss_back.sv
rtl/lcd_mode_scanline_sequencer_core.sv
rtl/lmss_checker.sv
bench/tb_top.sv
